// ===== sv/pgtc_pkg.sv =====
// package for the per-group traffic counter table
// holds the controller state type, status and direction codes, the counter record and field widths; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pgtc_pkg;

  localparam int unsigned ID_W    = 64;
  localparam int unsigned CNT_W   = 64;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned STAT_W  = 2;

  localparam logic [STAT_W-1:0] STAT_HIT    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INSERT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  localparam logic DIR_EGRESS  = 1'b0;
  localparam logic DIR_INGRESS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] rx_octets;
    logic [CNT_W-1:0] tx_octets;
    logic [CNT_W-1:0] rx_frames;
    logic [CNT_W-1:0] tx_frames;
  } counters_t;

endpackage

`default_nettype wire

// ===== sv/per_group_traffic_counter_table.sv =====
// per-group traffic counter table on a key memory and a counter memory; depends on pgtc_pkg
// keys are compared one entry per cycle from index 0 until a hit or the fill count; a hit
// then reads and updates the counter memory; the result waits in ST_FINISH while the output
// stalls, and the next transaction can be accepted in the same cycle the result appears
// entries fill from index 0 and are never freed, so a fill count stands in for valid bits
// synchronous reset clears the controller, the fill count and the output valid, not memories
`timescale 1ns / 1ps
`default_nettype none

module per_group_traffic_counter_table
  import pgtc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 512
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              opcode,
  input  wire logic [ID_W-1:0]   packet_group,
  input  wire logic [ID_W-1:0]   fallback_group,
  input  wire logic [LEN_W-1:0]  packet_length,
  input  wire logic [ID_W-1:0]   time_now,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [STAT_W-1:0]      status,
  output logic                   new_group_event,
  output logic [ID_W-1:0]        resolved_group,
  output logic [ID_W-1:0]        event_time,
  output logic [CNT_W-1:0]       rx_byte_total,
  output logic [CNT_W-1:0]       tx_byte_total,
  output logic [CNT_W-1:0]       rx_packet_total,
  output logic [CNT_W-1:0]       tx_packet_total
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  state_t state, state_next;

  logic [CW-1:0]   fill, fill_next;
  logic [CW-1:0]   scan_ptr, scan_ptr_next;
  logic            chk_valid, chk_valid_next;
  logic [IW-1:0]   chk_idx, chk_idx_next;
  logic [IW-1:0]   hit_idx, hit_idx_next;

  // captured transaction
  logic            dir;
  logic [ID_W-1:0] key;
  logic [LEN_W-1:0] len;
  logic [ID_W-1:0] tnow;

  // result held until the output register is free
  logic [STAT_W-1:0] res_status, res_status_next;
  logic              res_event, res_event_next;
  counters_t         res_cnt, res_cnt_next;

  // memories
  logic [ID_W-1:0]  key_mem [TABLE_ENTRIES];
  counters_t        cnt_mem [TABLE_ENTRIES];
  logic [ID_W-1:0]  key_q;
  counters_t        cnt_q;

  logic             key_we;
  logic             cnt_we;
  logic [IW-1:0]    cnt_waddr;
  counters_t        cnt_wdata;

  logic             accept;
  logic             out_free;
  logic             full;
  counters_t        first_cnt;
  counters_t        upd_cnt;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = (fill == CW'(TABLE_ENTRIES));

  always_comb begin
    first_cnt = '0;
    if (dir == DIR_INGRESS) begin
      first_cnt.rx_octets = {{(CNT_W-LEN_W){1'b0}}, len};
      first_cnt.rx_frames = CNT_W'(1);
    end else begin
      first_cnt.tx_octets = {{(CNT_W-LEN_W){1'b0}}, len};
      first_cnt.tx_frames = CNT_W'(1);
    end
  end

  always_comb begin
    upd_cnt = cnt_q;
    if (dir == DIR_INGRESS) begin
      upd_cnt.rx_octets = cnt_q.rx_octets + {{(CNT_W-LEN_W){1'b0}}, len};
      upd_cnt.rx_frames = cnt_q.rx_frames + CNT_W'(1);
    end else begin
      upd_cnt.tx_octets = cnt_q.tx_octets + {{(CNT_W-LEN_W){1'b0}}, len};
      upd_cnt.tx_frames = cnt_q.tx_frames + CNT_W'(1);
    end
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    scan_ptr_next   = scan_ptr;
    chk_valid_next  = 1'b0;
    chk_idx_next    = chk_idx;
    hit_idx_next    = hit_idx;
    res_status_next = res_status;
    res_event_next  = res_event;
    res_cnt_next    = res_cnt;
    key_we          = 1'b0;
    cnt_we          = 1'b0;
    cnt_waddr       = hit_idx;
    cnt_wdata       = upd_cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next    = ST_SCAN;
          scan_ptr_next = '0;
        end
      end
      ST_SCAN: begin
        if (chk_valid && key_q == key) begin
          hit_idx_next = chk_idx;
          state_next   = ST_READ;
        end else if (!chk_valid && scan_ptr == fill) begin
          // miss: insert at the fill point unless the table is full
          res_event_next = (dir == DIR_EGRESS);
          if (full) begin
            res_status_next = STAT_FULL;
            res_cnt_next    = '0;
          end else begin
            res_status_next = STAT_INSERT;
            res_cnt_next    = first_cnt;
            key_we          = 1'b1;
            cnt_we          = 1'b1;
            cnt_waddr       = fill[IW-1:0];
            cnt_wdata       = first_cnt;
            fill_next       = fill + CW'(1);
          end
          state_next = ST_FINISH;
        end else begin
          // key memory read issued at scan_ptr, compared next cycle
          chk_valid_next = (scan_ptr < fill);
          chk_idx_next   = scan_ptr[IW-1:0];
          if (scan_ptr < fill) begin
            scan_ptr_next = scan_ptr + CW'(1);
          end
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cnt_we          = 1'b1;
        res_status_next = STAT_HIT;
        res_event_next  = 1'b0;
        res_cnt_next    = upd_cnt;
        state_next      = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      chk_valid <= chk_valid_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr   <= scan_ptr_next;
    chk_idx    <= chk_idx_next;
    hit_idx    <= hit_idx_next;
    res_status <= res_status_next;
    res_event  <= res_event_next;
    res_cnt    <= res_cnt_next;
    if (accept) begin
      dir  <= opcode;
      key  <= (packet_group != '0) ? packet_group : fallback_group;
      len  <= packet_length;
      tnow <= time_now;
    end
    if (state == ST_FINISH && out_free) begin
      status          <= res_status;
      new_group_event <= res_event;
      resolved_group  <= key;
      event_time      <= res_event ? tnow : '0;
      rx_byte_total   <= res_cnt.rx_octets;
      tx_byte_total   <= res_cnt.tx_octets;
      rx_packet_total <= res_cnt.rx_frames;
      tx_packet_total <= res_cnt.tx_frames;
    end
  end

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[fill[IW-1:0]] <= key;
    end
    key_q <= key_mem[scan_ptr[IW-1:0]];
  end

  // counter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[hit_idx];
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for per_group_traffic_counter_table: random and directed packet events
// checked against a behavioral counter table; depends on pgtc_pkg and the dut
`timescale 1ns / 1ps

module tb_top
  import pgtc_pkg::*;
;

  localparam int unsigned ENTRIES = 512;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [STAT_W-1:0] stat;
    logic              evt;
    logic [ID_W-1:0]   key;
    logic [ID_W-1:0]   evt_time;
    counters_t         cnt;
  } count_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [ID_W-1:0] packet_group = '0;
  logic [ID_W-1:0] fallback_group = '0;
  logic [LEN_W-1:0] packet_length = '0;
  logic [ID_W-1:0] time_now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic new_group_event;
  logic [ID_W-1:0] resolved_group;
  logic [ID_W-1:0] event_time;
  logic [CNT_W-1:0] rx_byte_total;
  logic [CNT_W-1:0] tx_byte_total;
  logic [CNT_W-1:0] rx_packet_total;
  logic [CNT_W-1:0] tx_packet_total;

  per_group_traffic_counter_table #(.TABLE_ENTRIES(ENTRIES)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .packet_group(packet_group), .fallback_group(fallback_group),
    .packet_length(packet_length), .time_now(time_now),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .new_group_event(new_group_event),
    .resolved_group(resolved_group), .event_time(event_time),
    .rx_byte_total(rx_byte_total), .tx_byte_total(tx_byte_total),
    .rx_packet_total(rx_packet_total), .tx_packet_total(tx_packet_total)
  );

  always #5 clk = ~clk;

  // behavioral copy of the table
  int unsigned   fill_count = 0;
  logic [ID_W-1:0] group_keys [ENTRIES];
  counters_t     group_counts [ENTRIES];
  count_result_t pending_results [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit sender_idle_on = 1'b1;
  bit receiver_idle_on = 1'b1;
  bit long_hold = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned recv_idle_left = 0;

  function automatic count_result_t count_packet(input logic dir, input logic [ID_W-1:0] pg,
                                                 input logic [ID_W-1:0] fg,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [ID_W-1:0] now);
    count_result_t r;
    int idx;
    idx = -1;
    r = '0;
    r.key = (pg != '0) ? pg : fg;
    for (int i = 0; i < fill_count; i++)
      if (idx < 0 && group_keys[i] == r.key) idx = i;
    if (idx >= 0) begin
      r.stat = STAT_HIT;
    end else begin
      if (dir == DIR_EGRESS) begin
        r.evt = 1'b1;
        r.evt_time = now;
      end
      if (fill_count < ENTRIES) begin
        idx = fill_count;
        fill_count++;
        group_keys[idx] = r.key;
        group_counts[idx] = '0;
        r.stat = STAT_INSERT;
      end else begin
        r.stat = STAT_FULL;
      end
    end
    if (idx >= 0) begin
      if (dir == DIR_INGRESS) begin
        group_counts[idx].rx_octets += CNT_W'(len);
        group_counts[idx].rx_frames += CNT_W'(1);
      end else begin
        group_counts[idx].tx_octets += CNT_W'(len);
        group_counts[idx].tx_frames += CNT_W'(1);
      end
      r.cnt = group_counts[idx];
    end
    return r;
  endfunction

  task automatic send_packet(input logic dir, input logic [ID_W-1:0] pg,
                             input logic [ID_W-1:0] fg, input logic [LEN_W-1:0] len,
                             input logic [ID_W-1:0] now);
    if (sender_idle_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= dir;
    packet_group <= pg;
    fallback_group <= fg;
    packet_length <= len;
    time_now <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(count_packet(dir, pg, fg, len, now));
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 10) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // group pool keeps hits frequent
  logic [ID_W-1:0] group_pool [32];

  function automatic logic [ID_W-1:0] pick_group;
    case ($urandom_range(9))
      0: return '0;
      1: return rand64();
      default: return group_pool[$urandom_range(31)];
    endcase
  endfunction

  task automatic test_directed;
    send_packet(DIR_EGRESS, '0, '0, '0, '0);
    send_packet(DIR_INGRESS, '0, '0, '1, '1);
    send_packet(DIR_EGRESS, '1, 64'h5, '1, '1);
    send_packet(DIR_INGRESS, '0, '1, 16'h1, 64'h1234);
    send_packet(DIR_INGRESS, 64'h8000_0000_0000_0000, '0, 16'h8000, '1);
    send_packet(DIR_EGRESS, 64'h8000_0000_0000_0000, '1, 16'h7fff, 64'hdead_beef);
    send_packet(DIR_EGRESS, 64'h1, 64'h2, '0, '0);
    send_packet(DIR_EGRESS, 64'h1, 64'h2, '1, '1);
    send_packet(DIR_INGRESS, '0, 64'h1, 16'h55aa, 64'h77);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int n = 0; n < count; n++)
      send_packet(1'($urandom_range(1)), pick_group(), pick_group(),
                  ($urandom_range(7) == 0) ? LEN_W'($urandom_range(1) ? '1 : 0)
                                           : LEN_W'($urandom),
                  rand64());
  endtask

  // receiver holds off while the sender keeps offering transactions
  task automatic test_back_pressure;
    long_hold = 1'b1;
    test_random_traffic(20);
    long_hold = 1'b0;
  endtask

  // fill the table to capacity, then check drops and hits when full
  task automatic test_table_full;
    while (fill_count < ENTRIES) send_packet(1'($urandom_range(1)), rand64(), rand64(),
                                             LEN_W'($urandom), rand64());
    send_packet(DIR_EGRESS, rand64() | 64'h1, '0, '1, rand64());
    send_packet(DIR_INGRESS, rand64() | 64'h1, '0, '1, rand64());
    send_packet(DIR_EGRESS, '0, group_keys[0], '1, rand64());
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    for (int n = 0; n < 300; n++)
      send_packet(1'($urandom_range(1)),
                  $urandom_range(1) ? group_keys[$urandom_range(ENTRIES - 1)] : rand64(),
                  rand64(), LEN_W'($urandom), rand64());
  endtask

  // receiver idling comes in random bursts, or as a long hold during the back-pressure test
  always @(posedge clk) begin
    if (!rst) begin
      if (long_hold && hold_cycles < 2000) begin
        hold_cycles <= hold_cycles + 1;
        out_stall <= 1'b1;
      end else if (recv_idle_left != 0) begin
        recv_idle_left <= recv_idle_left - 1;
        out_stall <= 1'b1;
      end else if (receiver_idle_on && $urandom_range(4) == 0) begin
        recv_idle_left <= $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    count_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.stat) begin
          $error("status exp %0d got %0d", exp_r.stat, status); errors++;
        end
        if (new_group_event !== exp_r.evt) begin
          $error("new_group_event exp %0d got %0d", exp_r.evt, new_group_event); errors++;
        end
        if (resolved_group !== exp_r.key) begin
          $error("resolved_group exp %h got %h", exp_r.key, resolved_group); errors++;
        end
        if (event_time !== exp_r.evt_time) begin
          $error("event_time exp %h got %h", exp_r.evt_time, event_time); errors++;
        end
        if (rx_byte_total !== exp_r.cnt.rx_octets) begin
          $error("rx_byte_total exp %h got %h", exp_r.cnt.rx_octets, rx_byte_total); errors++;
        end
        if (tx_byte_total !== exp_r.cnt.tx_octets) begin
          $error("tx_byte_total exp %h got %h", exp_r.cnt.tx_octets, tx_byte_total); errors++;
        end
        if (rx_packet_total !== exp_r.cnt.rx_frames) begin
          $error("rx_packet_total exp %h got %h", exp_r.cnt.rx_frames, rx_packet_total);
          errors++;
        end
        if (tx_packet_total !== exp_r.cnt.tx_frames) begin
          $error("tx_packet_total exp %h got %h", exp_r.cnt.tx_frames, tx_packet_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) group_pool[i] = rand64();
    group_pool[0] = '1;
    group_pool[1] = 64'h1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic(500);
    test_back_pressure();
    test_random_traffic(600);
    test_table_full();
    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
